// ----- design/avcrl_pkg.sv -----
// Shared types and constants for the reference list slot encoder.
package avcrl_pkg;

    // Identifier that marks an empty frame store slot
    localparam logic [31:0] INVALID_ID = 32'hFFFF_FFFF;
    // Filler byte for unused list positions
    localparam logic [7:0]  PAD_BYTE   = 8'hFF;

    // Fixed field widths
    localparam int ID_W   = 32;
    localparam int SLOT_W = 4;
    localparam int POS_W  = 5;
    localparam int BYTE_W = 8;

    // Input item kind carried on tuser
    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_ENTRY = 1'b1;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SCAN = 4'b0010,
        ST_EMIT = 4'b0100,
        ST_PAD  = 4'b1000
    } enc_state_t;

endpackage

// ----- design/avc_ref_list_slot_encoder.sv -----
// Top level: frame store memory, slot search sequencer and list byte output.
//
//  channel  dir  handshake          payload
//  s_*      in   s_tvalid/s_tready  tuser=mode, tdata=slot..long_term, tlast=last_entry
//  m_*      out  m_tvalid/m_tready  tdata=entry_byte,position, tlast=list_done
//
// A slot write (mode 0) stores surface_id in the addressed slot. A list entry reads
// the frame store one slot per cycle through its single read port, then a matching
// entry emits one byte; padding after the last entry adds 0xFF bytes up to the list
// length. Entries are taken only while the sequencer is idle.
// Reset clears the slot valid bits and the byte count; no clearing pass is run.
// A stalled output holds the sequencer in its emit or pad state.
module avc_ref_list_slot_encoder
    import avcrl_pkg::*;
#(
    parameter int SLOTS    = 16,
    parameter int LIST_LEN = 32
)(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [3:0] slot, [35:4] surface_id, [36] entry_invalid, [37] top_field,
    // [38] bottom_field, [39] long_term
    input  logic [39:0] s_tdata,
    // [0] mode
    input  logic        s_tuser,
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] entry_byte, [12:8] position, [15:13] zero
    output logic [15:0] m_tdata,
    output logic        m_tlast
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(LIST_LEN + 1);

    // Input field views
    logic [SLOT_W-1:0] in_slot;
    logic [ID_W-1:0]   in_pid;
    logic              in_invalid;
    logic              in_top;
    logic              in_bot;
    logic              in_lt;
    logic              in_beat;

    assign in_slot    = s_tdata[3:0];
    assign in_pid     = s_tdata[35:4];
    assign in_invalid = s_tdata[36];
    assign in_top     = s_tdata[37];
    assign in_bot     = s_tdata[38];
    assign in_lt      = s_tdata[39];
    assign in_beat    = s_tvalid && s_tready;

    // Control state
    enc_state_t        state_reg, state_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [IW-1:0]     iss_reg, iss_next;
    logic              cmp_vld_reg, cmp_vld_next;
    logic [IW-1:0]     cmp_idx_reg, cmp_idx_next;
    logic [SLOTS-1:0]  slot_vld_reg, slot_vld_next;
    logic              m_tvalid_reg, m_tvalid_next;

    // Payload state
    logic [ID_W-1:0]   pid_reg, pid_next;
    logic              top_reg, top_next;
    logic              bot_reg, bot_next;
    logic              lt_reg, lt_next;
    logic              last_reg, last_next;
    logic [IW-1:0]     hit_idx_reg, hit_idx_next;
    logic [BYTE_W-1:0] out_byte_reg, out_byte_next;
    logic [POS_W-1:0]  out_pos_reg, out_pos_next;
    logic              out_done_reg, out_done_next;

    // Frame store memory
    logic [ID_W-1:0]   id_mem [SLOTS];
    logic [ID_W-1:0]   rd_data_reg;
    logic              mem_we;
    logic [IW-1:0]     wr_addr;

    logic              cmp_hit;
    logic              cnt_full;
    logic              out_free;
    logic              out_load;
    logic [BYTE_W-1:0] hit_byte;

    assign cmp_hit  = slot_vld_reg[cmp_idx_reg] && (rd_data_reg != INVALID_ID)
                      && (rd_data_reg == pid_reg);
    assign cnt_full = (cnt_reg == CW'(LIST_LEN));
    assign out_free = !m_tvalid_reg || m_tready;
    assign hit_byte = {1'b0, lt_reg, ~(top_reg ^ bot_reg), SLOT_W'(hit_idx_reg),
                       ~top_reg & bot_reg};
    assign wr_addr  = in_slot[IW-1:0];

    // Sequencer
    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        iss_next      = iss_reg;
        cmp_vld_next  = 1'b0;
        cmp_idx_next  = cmp_idx_reg;
        slot_vld_next = slot_vld_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        pid_next      = pid_reg;
        top_next      = top_reg;
        bot_next      = bot_reg;
        lt_next       = lt_reg;
        last_next     = last_reg;
        hit_idx_next  = hit_idx_reg;
        out_byte_next = out_byte_reg;
        out_pos_next  = out_pos_reg;
        out_done_next = out_done_reg;
        mem_we        = 1'b0;
        out_load      = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_beat)
                begin
                    if (s_tuser == MODE_WRITE)
                    begin
                        if ({1'b0, in_slot} < (SLOT_W + 1)'(SLOTS))
                        begin
                            mem_we                 = 1'b1;
                            slot_vld_next[wr_addr] = 1'b1;
                        end
                    end
                    else
                    begin
                        pid_next  = in_pid;
                        top_next  = in_top;
                        bot_next  = in_bot;
                        lt_next   = in_lt;
                        last_next = s_tlast;
                        if (!in_invalid)
                        begin
                            iss_next   = '0;
                            state_next = ST_SCAN;
                        end
                        else if (s_tlast)
                        begin
                            if (cnt_full)
                                cnt_next = '0;
                            else
                                state_next = ST_PAD;
                        end
                    end
                end
            end
            ST_SCAN:
            begin
                // one slot read issued per cycle, compared the cycle after
                iss_next     = iss_reg + IW'(1);
                cmp_vld_next = 1'b1;
                cmp_idx_next = iss_reg;
                if (cmp_vld_reg && (cmp_hit || cmp_idx_reg == IW'(SLOTS - 1)))
                begin
                    cmp_vld_next = 1'b0;
                    hit_idx_next = cmp_idx_reg;
                    if (cmp_hit && !cnt_full)
                        state_next = ST_EMIT;
                    else if (!last_reg)
                        state_next = ST_IDLE;
                    else if (cnt_full)
                    begin
                        cnt_next   = '0;
                        state_next = ST_IDLE;
                    end
                    else
                        state_next = ST_PAD;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_load      = 1'b1;
                    m_tvalid_next = 1'b1;
                    out_byte_next = hit_byte;
                    out_pos_next  = POS_W'(cnt_reg);
                    out_done_next = (cnt_reg == CW'(LIST_LEN - 1));
                    cnt_next      = cnt_reg + CW'(1);
                    state_next    = ST_IDLE;
                    if (last_reg)
                    begin
                        if (cnt_reg == CW'(LIST_LEN - 1))
                            cnt_next = '0;
                        else
                            state_next = ST_PAD;
                    end
                end
            end
            ST_PAD:
            begin
                if (out_free)
                begin
                    out_load      = 1'b1;
                    m_tvalid_next = 1'b1;
                    out_byte_next = PAD_BYTE;
                    out_pos_next  = POS_W'(cnt_reg);
                    out_done_next = (cnt_reg == CW'(LIST_LEN - 1));
                    if (cnt_reg == CW'(LIST_LEN - 1))
                    begin
                        cnt_next   = '0;
                        state_next = ST_IDLE;
                    end
                    else
                        cnt_next = cnt_reg + CW'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            iss_reg      <= '0;
            cmp_vld_reg  <= 1'b0;
            cmp_idx_reg  <= '0;
            slot_vld_reg <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            iss_reg      <= iss_next;
            cmp_vld_reg  <= cmp_vld_next;
            cmp_idx_reg  <= cmp_idx_next;
            slot_vld_reg <= slot_vld_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        pid_reg      <= pid_next;
        top_reg      <= top_next;
        bot_reg      <= bot_next;
        lt_reg       <= lt_next;
        last_reg     <= last_next;
        hit_idx_reg  <= hit_idx_next;
        out_byte_reg <= out_byte_next;
        out_pos_reg  <= out_pos_next;
        out_done_reg <= out_done_next;
    end

    // Frame store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            id_mem[wr_addr] <= in_pid;
        rd_data_reg <= id_mem[iss_reg];
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {3'b000, out_pos_reg, out_byte_reg};
    assign m_tlast  = out_done_reg;

    // Byte count never runs past the list length
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(LIST_LEN))
        else $error("byte count beyond list length");

    // Output beats are only produced by the emit and pad states
    a_load_state: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (state_reg == ST_EMIT || state_reg == ST_PAD))
        else $error("output loaded outside emit or pad");

    // A loaded byte never goes past the last list position
    a_load_room: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> !cnt_full)
        else $error("byte emitted with a full list");

    // A valid list entry starts a slot search
    a_scan_start: assert property (@(posedge clk) disable iff (!rst_n)
        (in_beat && s_tuser == MODE_ENTRY && !in_invalid)
        |=> (state_reg == ST_SCAN && !cmp_vld_reg && iss_reg == '0))
        else $error("entry did not start a search");

endmodule
